[rtl/smc_pkg.sv]
// smc_pkg: shared types, codes and helpers for the stall-gated motor command block
// no dependencies; used by smc_ctrl, smc_dpath and stall_gated_motor_command

package smc_pkg;

   // history window
   localparam int HISTORY_DEPTH = 16;
   localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   // field widths
   localparam int Q_W      = 32;
   localparam int KIND_W   = 3;
   localparam int STALL_W  = 2;
   localparam int EPS_W    = 16;
   localparam int WIN_W    = 5;
   localparam int CSR_AW   = 3;
   localparam int REQ_DW   = 104;
   localparam int RSP_DW   = 104;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_MIN_POSITION    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MAX_POSITION    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_POSITION_OFFSET = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_INVERT_DIR      = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_STALL_EPSILON   = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_LENGTH   = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_LIMIT_ENABLED   = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_IDLE_ON_ESTOP   = 3'd7;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_SAMPLE   = 3'd0;
   localparam logic [KIND_W-1:0] REQ_POSITION = 3'd1;
   localparam logic [KIND_W-1:0] REQ_VELOCITY = 3'd2;
   localparam logic [KIND_W-1:0] REQ_TORQUE   = 3'd3;
   localparam logic [KIND_W-1:0] REQ_ESTOP    = 3'd4;

   // drive kinds
   localparam logic [KIND_W-1:0] DRV_NONE     = 3'd0;
   localparam logic [KIND_W-1:0] DRV_POSITION = 3'd1;
   localparam logic [KIND_W-1:0] DRV_VELOCITY = 3'd2;
   localparam logic [KIND_W-1:0] DRV_TORQUE   = 3'd3;
   localparam logic [KIND_W-1:0] DRV_IDLE     = 3'd4;

   // stall codes
   localparam logic [STALL_W-1:0] STALL_MOVING  = 2'd0;
   localparam logic [STALL_W-1:0] STALL_TOP     = 2'd1;
   localparam logic [STALL_W-1:0] STALL_BOTTOM  = 2'd2;
   localparam logic [STALL_W-1:0] STALL_STOPPED = 2'd3;

   // estop beat indexes
   localparam logic [1:0] ESTOP_LAST_PLAIN = 2'd2;
   localparam logic [1:0] ESTOP_LAST_IDLE  = 2'd3;

   typedef struct packed {
      logic signed [Q_W-1:0] min_position;
      logic signed [Q_W-1:0] max_position;
      logic signed [Q_W-1:0] position_offset;
      logic                  invert_direction;
      logic [EPS_W-1:0]      stall_epsilon;
      logic [WIN_W-1:0]      window_length;
      logic                  limit_switch_enabled;
      logic                  idle_on_estop;
   } cfg_type;

   typedef enum logic [1:0] {
      RES_SAMPLE,
      RES_REJECT,
      RES_CMD,
      RES_ESTOP
   } res_sel_type;

   // controller to datapath
   typedef struct packed {
      logic               latch;
      logic               sample_upd;
      logic               walk_init;
      logic               walk_step;
      logic               stall_set;
      logic [STALL_W-1:0] stall_code;
      logic               load_out;
      res_sel_type        res_sel;
      logic [1:0]         estop_idx;
      logic               last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] req_kind;
      logic              range_bad;
      logic              top_hit;
      logic              too_few;
      logic              near;
      logic              walk_done;
      logic              at_bottom;
      logic              idle_on_estop;
   } dp_sts_type;

   // clamp a 33-bit signed sum into Q16.16
   function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] v);
      logic signed [Q_W-1:0] r;
      if (v[Q_W] != v[Q_W-1]) begin
         r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

   // optional sign flip with clamping
   function automatic logic signed [Q_W-1:0] apply_sign(input logic inv,
                                                         input logic signed [Q_W-1:0] v);
      logic signed [Q_W:0] n;
      n = -{v[Q_W-1], v};
      return inv ? sat33(n) : v;
   endfunction

endpackage

[rtl/smc_ctrl.sv]
// smc_ctrl: sequencing state machine of the stall-gated motor command block
// depends on smc_pkg; drives smc_dpath through dp_cmd_type, reads dp_sts_type

module smc_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [smc_pkg::KIND_W-1:0]     req_kind,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output smc_pkg::dp_cmd_type            cmd,
   input  smc_pkg::dp_sts_type            sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SAMPLE,
      S_CLASSIFY,
      S_PRIME,
      S_WALK,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   smc_pkg::res_sel_type sel_ff, sel_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 req_fire;
   logic                 emit_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign emit_last = (sel_ff != smc_pkg::RES_ESTOP) ||
                      (idx_ff == (sts.idle_on_estop ? smc_pkg::ESTOP_LAST_IDLE
                                                    : smc_pkg::ESTOP_LAST_PLAIN));

   always_comb begin
      cmd          = '0;
      cmd.res_sel  = sel_ff;
      cmd.estop_idx = idx_ff;
      cmd.last     = emit_last;
      state_in     = state_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch = req_fire;
            idx_in    = '0;
            if (req_fire) begin
               unique case (req_kind)
                  smc_pkg::REQ_SAMPLE: begin
                     state_in = S_SAMPLE;
                     sel_in   = smc_pkg::RES_SAMPLE;
                  end
                  smc_pkg::REQ_POSITION, smc_pkg::REQ_VELOCITY, smc_pkg::REQ_TORQUE: begin
                     state_in = S_CLASSIFY;
                     sel_in   = smc_pkg::RES_CMD;
                  end
                  smc_pkg::REQ_ESTOP: begin
                     state_in = S_EMIT;
                     sel_in   = smc_pkg::RES_ESTOP;
                  end
                  default: begin
                     state_in = S_EMIT;
                     sel_in   = smc_pkg::RES_REJECT;
                  end
               endcase
            end
         end
         S_SAMPLE: begin
            cmd.sample_upd = 1'b1;
            state_in       = S_EMIT;
         end
         S_CLASSIFY: begin
            priority if (sts.req_kind == smc_pkg::REQ_POSITION && sts.range_bad) begin
               sel_in   = smc_pkg::RES_REJECT;
               state_in = S_EMIT;
            end else if (sts.top_hit) begin
               cmd.stall_set  = 1'b1;
               cmd.stall_code = smc_pkg::STALL_TOP;
               state_in       = S_EMIT;
            end else if (sts.too_few) begin
               cmd.stall_set  = 1'b1;
               cmd.stall_code = smc_pkg::STALL_MOVING;
               state_in       = S_EMIT;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = S_PRIME;
            end
         end
         S_PRIME: begin
            cmd.walk_step = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            priority if (!sts.near) begin
               cmd.stall_set  = 1'b1;
               cmd.stall_code = smc_pkg::STALL_MOVING;
               state_in       = S_EMIT;
            end else if (sts.walk_done) begin
               cmd.stall_set  = 1'b1;
               cmd.stall_code = sts.at_bottom ? smc_pkg::STALL_BOTTOM
                                              : smc_pkg::STALL_STOPPED;
               state_in       = S_EMIT;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= smc_pkg::RES_REJECT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/smc_dpath.sv]
// smc_dpath: position/velocity state, history memory, window compare and result register
// depends on smc_pkg; steered by smc_ctrl

module smc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  smc_pkg::cfg_type                    cfg,
   input  smc_pkg::dp_cmd_type                 cmd,
   output smc_pkg::dp_sts_type                 sts,
   input  logic [smc_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [smc_pkg::Q_W-1:0]      feedback_position,
   input  logic signed [smc_pkg::Q_W-1:0]      feedback_velocity,
   input  logic signed [smc_pkg::Q_W-1:0]      command_value,
   input  logic                                limit_switch_low,
   output logic [smc_pkg::KIND_W-1:0]          drive_kind,
   output logic signed [smc_pkg::Q_W-1:0]      drive_value,
   output logic                                accepted,
   output logic [smc_pkg::STALL_W-1:0]         stall_state,
   output logic signed [smc_pkg::Q_W-1:0]      position,
   output logic signed [smc_pkg::Q_W-1:0]      velocity,
   output logic                                last
);

   localparam int QW = smc_pkg::Q_W;
   localparam int AW = smc_pkg::HIST_AW;
   localparam int CW = smc_pkg::CNT_W;
   localparam logic [AW-1:0] PTR_TOP = AW'(smc_pkg::HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(smc_pkg::HISTORY_DEPTH);

   // latched request
   logic [smc_pkg::KIND_W-1:0] kind_ff;
   logic signed [QW-1:0]       fbp_ff, fbv_ff, cmdv_ff;
   logic                       sw_ff;

   // axis state
   logic signed [QW-1:0]         pos_ff, pos_in, vel_ff, vel_in;
   logic [AW-1:0]                wp_ff;
   logic [CW-1:0]                cnt_ff;
   logic [smc_pkg::STALL_W-1:0]  stall_ff;

   // window walk
   logic signed [QW-1:0] hist_mem [smc_pkg::HISTORY_DEPTH];
   logic signed [QW-1:0] rd_data_ff;
   logic [AW-1:0]        rd_ptr_ff;
   logic [CW-1:0]        left_ff;
   logic [CW-1:0]        win;

   // result register
   logic [smc_pkg::KIND_W-1:0]  kind_out_ff, kind_res;
   logic signed [QW-1:0]        value_out_ff, value_res;
   logic                        acc_out_ff, acc_res;
   logic [smc_pkg::STALL_W-1:0] stall_out_ff;
   logic signed [QW-1:0]        pos_out_ff, vel_out_ff;
   logic                        last_out_ff;

   logic signed [QW+1:0] diff, eps_x;
   logic signed [QW-1:0] target, signed_cmd;
   logic                 stalled, ok;

   // window length clamped to 1..depth
   always_comb begin
      if (cfg.window_length == '0) begin
         win = CW'(1);
      end else if (32'(cfg.window_length) > 32'(smc_pkg::HISTORY_DEPTH)) begin
         win = CNT_MAX;
      end else begin
         win = CW'(cfg.window_length);
      end
   end

   assign eps_x = $signed({{(QW+2-smc_pkg::EPS_W){1'b0}}, cfg.stall_epsilon});
   assign diff  = {{2{rd_data_ff[QW-1]}}, rd_data_ff} - {{2{pos_ff[QW-1]}}, pos_ff};

   always_comb begin
      sts.req_kind      = kind_ff;
      sts.range_bad     = (cmdv_ff < cfg.min_position) || (cmdv_ff > cfg.max_position);
      sts.top_hit       = cfg.limit_switch_enabled && sw_ff;
      sts.too_few       = cnt_ff < win;
      sts.near          = (diff <= eps_x) && (diff >= -eps_x);
      sts.walk_done     = (left_ff == '0);
      sts.at_bottom     = $signed({{2{pos_ff[QW-1]}}, pos_ff}) <=
                          ($signed({{2{cfg.min_position[QW-1]}}, cfg.min_position}) + eps_x);
      sts.idle_on_estop = cfg.idle_on_estop;
   end

   // corrected feedback
   always_comb begin
      if (cfg.invert_direction) begin
         pos_in = smc_pkg::sat33({cfg.position_offset[QW-1], cfg.position_offset} +
                                 {fbp_ff[QW-1], fbp_ff});
      end else begin
         pos_in = smc_pkg::sat33({cfg.position_offset[QW-1], cfg.position_offset} -
                                 {fbp_ff[QW-1], fbp_ff});
      end
      vel_in = smc_pkg::apply_sign(cfg.invert_direction, fbv_ff);
   end

   // command decision on the freshly classified stall state
   always_comb begin
      signed_cmd = smc_pkg::apply_sign(cfg.invert_direction, cmdv_ff);
      target     = smc_pkg::sat33({cfg.position_offset[QW-1], cfg.position_offset} -
                                  {signed_cmd[QW-1], signed_cmd});
      if (cfg.invert_direction && cmdv_ff == {1'b1, {(QW-1){1'b0}}}) begin
         // flipped minimum clamps one short, so add straight from the raw value
         target = smc_pkg::sat33({cfg.position_offset[QW-1], cfg.position_offset} +
                                 {cmdv_ff[QW-1], cmdv_ff});
      end
      stalled = (stall_ff != smc_pkg::STALL_MOVING);
      if (kind_ff == smc_pkg::REQ_POSITION) begin
         ok = !stalled ||
              ((stall_ff == smc_pkg::STALL_TOP || stall_ff == smc_pkg::STALL_STOPPED) &&
               (cmdv_ff > pos_ff)) ||
              ((stall_ff == smc_pkg::STALL_BOTTOM) && (cmdv_ff < pos_ff));
      end else begin
         ok = !stalled ||
              ((stall_ff == smc_pkg::STALL_TOP) && cmdv_ff[QW-1]) ||
              ((stall_ff == smc_pkg::STALL_BOTTOM) && !cmdv_ff[QW-1] && (cmdv_ff != '0));
      end
   end

   always_comb begin
      kind_res  = smc_pkg::DRV_NONE;
      value_res = '0;
      acc_res   = 1'b0;
      unique case (cmd.res_sel)
         smc_pkg::RES_SAMPLE: begin
            acc_res = 1'b1;
         end
         smc_pkg::RES_REJECT: begin
            acc_res = 1'b0;
         end
         smc_pkg::RES_CMD: begin
            acc_res = ok;
            if (kind_ff == smc_pkg::REQ_POSITION) begin
               kind_res  = ok ? smc_pkg::DRV_POSITION : smc_pkg::DRV_NONE;
               value_res = ok ? target : '0;
            end else begin
               kind_res  = kind_ff;
               value_res = ok ? signed_cmd : '0;
            end
         end
         smc_pkg::RES_ESTOP: begin
            acc_res = 1'b1;
            unique case (cmd.estop_idx)
               2'd0:    kind_res = smc_pkg::DRV_POSITION;
               2'd1:    kind_res = smc_pkg::DRV_VELOCITY;
               2'd2:    kind_res = smc_pkg::DRV_TORQUE;
               default: kind_res = smc_pkg::DRV_IDLE;
            endcase
         end
         default: begin
            acc_res = 1'b0;
         end
      endcase
   end

   // request payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         fbp_ff  <= feedback_position;
         fbv_ff  <= feedback_velocity;
         cmdv_ff <= command_value;
         sw_ff   <= limit_switch_low;
      end
   end

   // history store and its read port
   always_ff @(posedge clock) begin
      if (cmd.sample_upd) begin
         hist_mem[wp_ff] <= pos_in;
      end
      if (cmd.walk_step) begin
         rd_data_ff <= hist_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         vel_ff    <= '0;
         wp_ff     <= '0;
         cnt_ff    <= '0;
         stall_ff  <= smc_pkg::STALL_STOPPED;
         rd_ptr_ff <= '0;
         left_ff   <= '0;
      end else begin
         if (cmd.sample_upd) begin
            pos_ff <= pos_in;
            vel_ff <= vel_in;
            wp_ff  <= (wp_ff == PTR_TOP) ? '0 : wp_ff + AW'(1);
            if (cnt_ff != CNT_MAX) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         if (cmd.stall_set) begin
            stall_ff <= cmd.stall_code;
         end
         if (cmd.walk_init) begin
            rd_ptr_ff <= (wp_ff == '0) ? PTR_TOP : wp_ff - AW'(1);
            left_ff   <= win;
         end else if (cmd.walk_step) begin
            rd_ptr_ff <= (rd_ptr_ff == '0) ? PTR_TOP : rd_ptr_ff - AW'(1);
            left_ff   <= left_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         kind_out_ff  <= kind_res;
         value_out_ff <= value_res;
         acc_out_ff   <= acc_res;
         stall_out_ff <= stall_ff;
         pos_out_ff   <= pos_ff;
         vel_out_ff   <= vel_ff;
         last_out_ff  <= cmd.last;
      end
   end

   assign drive_kind  = kind_out_ff;
   assign drive_value = value_out_ff;
   assign accepted    = acc_out_ff;
   assign stall_state = stall_out_ff;
   assign position    = pos_out_ff;
   assign velocity    = vel_out_ff;
   assign last        = last_out_ff;

endmodule

[rtl/stall_gated_motor_command.sv]
// stall_gated_motor_command: top level with register bank, stream packing and both halves
// depends on smc_pkg, smc_ctrl and smc_dpath
//
// channel | direction | beat contents
// req     | in        | tuser request kind; tdata feedback position, velocity, command, switch
// rsp     | out       | tuser drive kind; tdata value, accepted, stall, position, velocity
// csr     | in        | write enable, register index, write data (no read-back)
//
// a sample updates the axis state in S_SAMPLE and loads the result register in S_EMIT; a
// position, velocity or torque command passes S_CLASSIFY, then S_PRIME and S_WALK when the window
// is walked (one history entry per cycle through the single history read port), then S_EMIT
// an estop goes straight to S_EMIT and loads one beat per cycle while the result side takes them
// reset is synchronous and active high; the history memory is not cleared
// a new request is taken once the last beat of the previous one sits in the result register

module stall_gated_motor_command (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [smc_pkg::REQ_DW-1:0]         req_tdata,  // feedback_position, feedback_velocity,
                                                          // command_value, limit_switch_low, pad
   input  logic [smc_pkg::KIND_W-1:0]         req_tuser,  // req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [smc_pkg::RSP_DW-1:0]         rsp_tdata,  // drive_value, accepted, stall_state,
                                                          // position, velocity, pad
   output logic [smc_pkg::KIND_W-1:0]         rsp_tuser,  // drive_kind
   output logic                               rsp_tlast,
   // register write port
   input  logic                               csr_we,
   input  logic [smc_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [smc_pkg::Q_W-1:0]            csr_wdata
);

   localparam int QW = smc_pkg::Q_W;

   smc_pkg::cfg_type    cfg_ff;
   smc_pkg::dp_cmd_type cmd;
   smc_pkg::dp_sts_type sts;

   logic [smc_pkg::KIND_W-1:0]  drive_kind;
   logic signed [QW-1:0]        drive_value;
   logic                        accepted;
   logic [smc_pkg::STALL_W-1:0] stall_state;
   logic signed [QW-1:0]        position;
   logic signed [QW-1:0]        velocity;
   logic                        last;

   // register bank, to be written only while the block is quiet; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_position         <= '0;
         cfg_ff.max_position         <= 32'sd1703936;
         cfg_ff.position_offset      <= '0;
         cfg_ff.invert_direction     <= 1'b1;
         cfg_ff.stall_epsilon        <= 16'd7;
         cfg_ff.window_length        <= 5'd10;
         cfg_ff.limit_switch_enabled <= 1'b1;
         cfg_ff.idle_on_estop        <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            smc_pkg::CSR_MIN_POSITION:    cfg_ff.min_position    <= csr_wdata;
            smc_pkg::CSR_MAX_POSITION:    cfg_ff.max_position    <= csr_wdata;
            smc_pkg::CSR_POSITION_OFFSET: cfg_ff.position_offset <= csr_wdata;
            smc_pkg::CSR_INVERT_DIR:      cfg_ff.invert_direction <= csr_wdata[0];
            smc_pkg::CSR_STALL_EPSILON:   cfg_ff.stall_epsilon <= csr_wdata[smc_pkg::EPS_W-1:0];
            smc_pkg::CSR_WINDOW_LENGTH:   cfg_ff.window_length <= csr_wdata[smc_pkg::WIN_W-1:0];
            smc_pkg::CSR_LIMIT_ENABLED:   cfg_ff.limit_switch_enabled <= csr_wdata[0];
            smc_pkg::CSR_IDLE_ON_ESTOP:   cfg_ff.idle_on_estop <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // sequencing
   smc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // arithmetic, history and result register; request fields unpacked from the beat
   smc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_tuser),
      .feedback_position (req_tdata[31:0]),
      .feedback_velocity (req_tdata[63:32]),
      .command_value     (req_tdata[95:64]),
      .limit_switch_low  (req_tdata[96]),
      .drive_kind        (drive_kind),
      .drive_value       (drive_value),
      .accepted          (accepted),
      .stall_state       (stall_state),
      .position          (position),
      .velocity          (velocity),
      .last              (last)
   );

   // result beat packing, zero pad up to whole bytes
   assign rsp_tdata = {5'd0, velocity, position, stall_state, accepted, drive_value};
   assign rsp_tuser = drive_kind;
   assign rsp_tlast = last;

endmodule
